// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level of the charge permission block
// depends on a clock named clk and an active low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charge permission assertion failed");

// next-cycle implication, disabled during reset
`define BCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charge permission assertion failed");

`endif

// ===== rtl/bcp_pkg.sv =====
// types, codes and helpers of the battery charge permission block
// no dependencies; used by the interfaces, the controller and the top level
`default_nettype none

package bcp_pkg;

    // controller states
    localparam logic [2:0] ST_WAIT         = 3'd0;
    localparam logic [2:0] ST_CHARGING     = 3'd1;
    localparam logic [2:0] ST_PROBE_OFF    = 3'd2;
    localparam logic [2:0] ST_PROBE_SAMPLE = 3'd3;
    localparam logic [2:0] ST_FULL_HOLD    = 3'd4;
    localparam logic [2:0] ST_FAULT_HOLD   = 3'd5;

    // charger presence
    localparam logic [1:0] PR_UNKNOWN = 2'd0;
    localparam logic [1:0] PR_PRESENT = 2'd1;
    localparam logic [1:0] PR_ABSENT  = 2'd2;

    // close reasons
    localparam logic [2:0] RS_NONE         = 3'd0;
    localparam logic [2:0] RS_NO_CHARGER   = 3'd1;
    localparam logic [2:0] RS_DATA_INVALID = 3'd2;
    localparam logic [2:0] RS_PROTECTION   = 3'd3;
    localparam logic [2:0] RS_PROBE        = 3'd4;
    localparam logic [2:0] RS_FULL         = 3'd5;

    // pack modes
    localparam logic [1:0] MD_STARTUP = 2'd0;
    localparam logic [1:0] MD_IDLE    = 2'd1;
    localparam logic [1:0] MD_DSG     = 2'd2;
    localparam logic [1:0] MD_CHG     = 2'd3;

    // cell plausibility limits in mV
    localparam logic [15:0] CELL_MIN_VALID_MV = 16'd1000;
    localparam logic [15:0] CELL_MAX_VALID_MV = 16'd5000;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_EVIDENCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PACK        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CELL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE_PACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE_CELL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_CONFIRM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_CURRENT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE_CONFIRM = 3'd7;

    typedef struct packed {
        logic        charger_detect;
        logic        load_detect;
        logic        prot_permit;
        logic [12:0] fault_flags;
        logic [15:0] cell_min_mv;
        logic [15:0] cell_max_mv;
        logic [15:0] pack_voltage;
        logic [15:0] charge_current;
        logic [5:0]  series_count;
    } req_t;

    typedef struct packed {
        logic       charge_mos_on;
        logic       charge_demand;
        logic       discharge_force_off;
        logic [2:0] controller_state;
        logic [1:0] charger_presence;
        logic [2:0] stop_cause;
        logic [1:0] pack_mode;
        logic       detect_low_seen;
    } rsp_t;

    typedef struct packed {
        logic [15:0] charge_evidence_current;
        logic [15:0] full_pack_voltage;
        logic [15:0] full_cell_mv;
        logic [15:0] recharge_pack_voltage;
        logic [15:0] recharge_cell_mv;
        logic [15:0] present_confirm_ticks;
        logic [15:0] no_current_ticks;
        logic [15:0] recharge_confirm_ticks;
    } cfg_t;

    // controller state carried between ticks
    typedef struct packed {
        logic [2:0]  st;
        logic [1:0]  presence;
        logic [2:0]  reason;
        logic [15:0] low_cnt;
        logic [15:0] high_cnt;
        logic [15:0] idle_cnt;
        logic [15:0] rech_cnt;
        logic        det_sampled;
    } ctrl_t;

    // saturating increment, stops at the limit
    function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] lim);
        return (v < lim) ? v + 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bcp_if.sv =====
// request and response channel interfaces with valid/ready handshake
// depends on bcp_pkg for the payload types
`default_nettype none

interface bcp_req_if;
    import bcp_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcp_rsp_if;
    import bcp_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcp_ctrl.sv =====
// next-state logic of the six-state charge controller and its counters
// depends on bcp_pkg
`default_nettype none

module bcp_ctrl #(
    parameter int unsigned ABSENT_CONFIRM_TICKS = 10,
    parameter int unsigned PROBE_SETTLE_TICKS   = 10,
    parameter int unsigned TARGET_SERIES        = 16
) (
    input  bcp_pkg::ctrl_t cur,
    input  bcp_pkg::cfg_t  cfg,
    input  bcp_pkg::req_t  item,
    output bcp_pkg::ctrl_t nxt,
    output logic           req
);
    import bcp_pkg::*;

    localparam logic [15:0] ABSENT_LIM = 16'(ABSENT_CONFIRM_TICKS);
    localparam logic [15:0] SETTLE_LIM = 16'(PROBE_SETTLE_TICKS);
    localparam logic [5:0]  SERIES     = 6'(TARGET_SERIES);

    typedef struct packed {
        logic [1:0]  presence;
        logic [15:0] low_cnt;
        logic [15:0] high_cnt;
    } pres_upd_t;

    // debounce of the charger detect pin
    function automatic pres_upd_t upd_presence(input logic det, input logic [1:0] pr,
                                               input logic [15:0] lo, input logic [15:0] hi,
                                               input logic [15:0] lim);
        pres_upd_t r;
        r.presence = pr;
        if (det)
        begin
            if (pr == PR_ABSENT)
                r.presence = PR_UNKNOWN;
            r.low_cnt  = sat_inc(lo, lim);
            r.high_cnt = 16'd0;
            if (r.low_cnt >= lim)
                r.presence = PR_PRESENT;
        end
        else
        begin
            if (pr == PR_PRESENT)
                r.presence = PR_UNKNOWN;
            r.high_cnt = sat_inc(hi, ABSENT_LIM);
            r.low_cnt  = 16'd0;
            if (r.high_cnt >= ABSENT_LIM)
                r.presence = PR_ABSENT;
        end
        return r;
    endfunction

    logic      data_bad;
    logic      prot_block;
    logic      full_zone;
    logic      rech_zone;
    pres_upd_t pu;

    assign data_bad = (item.series_count != SERIES)
                   || (item.cell_min_mv < CELL_MIN_VALID_MV)
                   || (item.cell_max_mv > CELL_MAX_VALID_MV)
                   || (item.cell_max_mv < item.cell_min_mv)
                   || (item.pack_voltage == 16'd0);
    assign prot_block = !item.prot_permit || (|item.fault_flags);
    assign full_zone = (item.pack_voltage >= cfg.full_pack_voltage)
                    && (item.cell_max_mv >= cfg.full_cell_mv);
    assign rech_zone = (item.pack_voltage <= cfg.recharge_pack_voltage)
                    && (item.cell_max_mv <= cfg.recharge_cell_mv);
    assign pu = upd_presence(item.charger_detect, cur.presence, cur.low_cnt, cur.high_cnt,
                             cfg.present_confirm_ticks);

    always_comb
    begin
        nxt = cur;
        req = 1'b0;
        if (data_bad || prot_block)
        begin
            nxt.st       = ST_FAULT_HOLD;
            nxt.presence = PR_UNKNOWN;
            nxt.reason   = data_bad ? RS_DATA_INVALID : RS_PROTECTION;
            nxt.low_cnt  = 16'd0;
            nxt.high_cnt = 16'd0;
            nxt.idle_cnt = 16'd0;
            nxt.rech_cnt = 16'd0;
        end
        else
        begin
            case (cur.st)
                ST_WAIT:
                begin
                    nxt.reason      = RS_NO_CHARGER;
                    nxt.det_sampled = item.charger_detect;
                    nxt.presence    = pu.presence;
                    nxt.low_cnt     = pu.low_cnt;
                    nxt.high_cnt    = pu.high_cnt;
                    if (pu.presence == PR_PRESENT)
                    begin
                        nxt.st       = ST_CHARGING;
                        nxt.reason   = RS_NONE;
                        nxt.idle_cnt = 16'd0;
                        req          = 1'b1;
                    end
                end
                ST_CHARGING:
                begin
                    nxt.presence = PR_UNKNOWN;
                    nxt.low_cnt  = 16'd0;
                    nxt.high_cnt = 16'd0;
                    nxt.reason   = RS_NONE;
                    req          = 1'b1;
                    if (item.charge_current >= cfg.charge_evidence_current)
                        nxt.idle_cnt = 16'd0;
                    else
                    begin
                        nxt.idle_cnt = sat_inc(cur.idle_cnt, cfg.no_current_ticks);
                        if (nxt.idle_cnt >= cfg.no_current_ticks)
                        begin
                            nxt.st       = ST_PROBE_OFF;
                            nxt.reason   = RS_PROBE;
                            nxt.idle_cnt = 16'd0;
                            req          = 1'b0;
                        end
                    end
                end
                ST_PROBE_OFF:
                begin
                    nxt.reason   = RS_PROBE;
                    nxt.high_cnt = sat_inc(cur.high_cnt, SETTLE_LIM);
                    if (nxt.high_cnt >= SETTLE_LIM)
                    begin
                        nxt.st       = ST_PROBE_SAMPLE;
                        nxt.low_cnt  = 16'd0;
                        nxt.high_cnt = 16'd0;
                    end
                end
                ST_PROBE_SAMPLE:
                begin
                    nxt.reason      = RS_PROBE;
                    nxt.det_sampled = item.charger_detect;
                    nxt.presence    = pu.presence;
                    nxt.low_cnt     = pu.low_cnt;
                    nxt.high_cnt    = pu.high_cnt;
                    if (full_zone)
                    begin
                        nxt.st       = ST_FULL_HOLD;
                        nxt.presence = PR_UNKNOWN;
                        nxt.reason   = RS_FULL;
                        nxt.low_cnt  = 16'd0;
                        nxt.high_cnt = 16'd0;
                        nxt.rech_cnt = 16'd0;
                    end
                    else if (pu.presence == PR_ABSENT)
                    begin
                        nxt.st     = ST_WAIT;
                        nxt.reason = RS_NO_CHARGER;
                    end
                end
                ST_FULL_HOLD:
                begin
                    nxt.reason      = RS_FULL;
                    nxt.det_sampled = item.charger_detect;
                    nxt.presence    = pu.presence;
                    nxt.low_cnt     = pu.low_cnt;
                    nxt.high_cnt    = pu.high_cnt;
                    if (rech_zone && pu.presence == PR_PRESENT)
                    begin
                        nxt.rech_cnt = sat_inc(cur.rech_cnt, cfg.recharge_confirm_ticks);
                        if (nxt.rech_cnt >= cfg.recharge_confirm_ticks)
                        begin
                            nxt.st       = ST_CHARGING;
                            nxt.reason   = RS_NONE;
                            nxt.rech_cnt = 16'd0;
                            req          = 1'b1;
                        end
                    end
                    else
                        nxt.rech_cnt = 16'd0;
                end
                default:
                begin
                    // fault hold and unused codes: restart from wait
                    nxt.st       = ST_WAIT;
                    nxt.presence = PR_UNKNOWN;
                    nxt.reason   = RS_NO_CHARGER;
                    nxt.low_cnt  = 16'd0;
                    nxt.high_cnt = 16'd0;
                    nxt.idle_cnt = 16'd0;
                    nxt.rech_cnt = 16'd0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/battery_charge_permission_fsm_top.sv =====
// top level of the battery charge permission block: channels, config, pack mode
// depends on bcp_pkg, bcp_if, bcp_ctrl and assert_macros.svh
`default_nettype none

// One request is one control tick: charger and load detect pins, upstream
// charge permission, fault bits and pack measurements. The block answers each
// request with exactly one response carrying the charge MOS drive, the charge
// request, the discharge force-off, the controller state, the debounced charger
// presence, the close reason, the pack mode and the last sampled detect bit.
// Throughput is one request per clock while responses are taken. The accepting
// edge loads the input register; the controller update then runs on it and its
// result is loaded into the response register, which raises response valid.
// Requests keep flowing while a response waits, and a stalled response stalls
// the input register only when both are full. Thresholds are written through
// the cfg port (index 0..7 in register order); the user must write them only
// while no request is in flight, which the block does not enforce. Reset loads
// their default values. Invalid measurements or any fault force fault hold; the
// first clean tick after that returns the controller to waiting for a charger.

module battery_charge_permission_fsm_top #(
    parameter int unsigned ABSENT_CONFIRM_TICKS = 10,
    parameter int unsigned PROBE_SETTLE_TICKS   = 10,
    parameter int unsigned TARGET_SERIES        = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    bcp_req_if.sink                            in_ch,
    bcp_rsp_if.source                          out_ch
);
    import bcp_pkg::*;

`include "assert_macros.svh"

    // configuration registers
    cfg_t cfg_reg;

    // pipeline registers
    logic  in_vld_reg;
    req_t  in_data_reg;
    logic  out_vld_reg;
    rsp_t  out_data_reg;

    // controller and pack-mode state
    ctrl_t      ctrl_reg;
    ctrl_t      ctrl_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;

    logic advance;
    logic fire;
    logic req;
    logic force_off;
    logic load;
    logic chg;

    // response register frees when empty or being taken
    assign advance      = !out_vld_reg || out_ch.ready;
    assign fire         = in_vld_reg && advance;
    assign in_ch.ready  = !in_vld_reg || advance;
    assign out_ch.valid   = out_vld_reg;
    assign out_ch.payload = out_data_reg;

    assign load = in_data_reg.load_detect;
    assign chg  = in_data_reg.charger_detect;

    // controller next state from the registered request
    bcp_ctrl #(
        .ABSENT_CONFIRM_TICKS(ABSENT_CONFIRM_TICKS),
        .PROBE_SETTLE_TICKS  (PROBE_SETTLE_TICKS),
        .TARGET_SERIES       (TARGET_SERIES)
    ) u_ctrl (
        .cur (ctrl_reg),
        .cfg (cfg_reg),
        .item(in_data_reg),
        .nxt (ctrl_next),
        .req (req)
    );

    // pack-mode machine: pin-driven transitions first, then controller result
    always_comb
    begin
        force_off = 1'b0;
        mode_next = mode_reg;
        case (mode_reg)
            MD_STARTUP, MD_IDLE:
            begin
                force_off = 1'b1;
                if (load)
                    mode_next = MD_DSG;
                if (chg)
                    mode_next = MD_CHG;
            end
            MD_DSG:
            begin
                if (!load)
                    mode_next = MD_IDLE;
                if (chg)
                    mode_next = MD_CHG;
            end
            default:
            begin
                // charging mode: no load means discharge stays off
                if (!load)
                    force_off = 1'b1;
            end
        endcase
        if (req)
            mode_next = MD_CHG;
        else if (mode_next == MD_CHG && ctrl_next.st == ST_WAIT
                 && ctrl_next.presence == PR_ABSENT)
            mode_next = load ? MD_DSG : MD_IDLE;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_evidence_current <= 16'd10;
            cfg_reg.full_pack_voltage       <= 16'd5840;
            cfg_reg.full_cell_mv            <= 16'd3650;
            cfg_reg.recharge_pack_voltage   <= 16'd5440;
            cfg_reg.recharge_cell_mv        <= 16'd3400;
            cfg_reg.present_confirm_ticks   <= 16'd10;
            cfg_reg.no_current_ticks        <= 16'd500;
            cfg_reg.recharge_confirm_ticks  <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHARGE_EVIDENCE:  cfg_reg.charge_evidence_current <= cfg_data;
                CFG_FULL_PACK:        cfg_reg.full_pack_voltage       <= cfg_data;
                CFG_FULL_CELL:        cfg_reg.full_cell_mv            <= cfg_data;
                CFG_RECHARGE_PACK:    cfg_reg.recharge_pack_voltage   <= cfg_data;
                CFG_RECHARGE_CELL:    cfg_reg.recharge_cell_mv        <= cfg_data;
                CFG_PRESENT_CONFIRM:  cfg_reg.present_confirm_ticks   <= cfg_data;
                CFG_NO_CURRENT:       cfg_reg.no_current_ticks        <= cfg_data;
                CFG_RECHARGE_CONFIRM: cfg_reg.recharge_confirm_ticks  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // valid bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
            ctrl_reg.st          <= ST_WAIT;
            ctrl_reg.presence    <= PR_UNKNOWN;
            ctrl_reg.reason      <= RS_NO_CHARGER;
            ctrl_reg.low_cnt     <= 16'd0;
            ctrl_reg.high_cnt    <= 16'd0;
            ctrl_reg.idle_cnt    <= 16'd0;
            ctrl_reg.rech_cnt    <= 16'd0;
            ctrl_reg.det_sampled <= 1'b0;
            mode_reg             <= MD_STARTUP;
        end
        else
        begin
            if (in_ch.ready)
                in_vld_reg <= in_ch.valid;
            if (advance)
                out_vld_reg <= in_vld_reg;
            if (fire)
            begin
                ctrl_reg <= ctrl_next;
                mode_reg <= mode_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_data_reg <= in_ch.payload;
        if (fire)
        begin
            out_data_reg.charge_mos_on       <= in_data_reg.prot_permit & req;
            out_data_reg.charge_demand       <= req;
            out_data_reg.discharge_force_off <= force_off;
            out_data_reg.controller_state    <= ctrl_next.st;
            out_data_reg.charger_presence    <= ctrl_next.presence;
            out_data_reg.stop_cause          <= ctrl_next.reason;
            out_data_reg.pack_mode           <= mode_next;
            out_data_reg.detect_low_seen     <= ctrl_next.det_sampled;
        end
    end

    // a charge request always leaves the pack in charging mode
    `BCP_ASSERT_NEXT(a_req_sets_chg_mode, fire && req, mode_reg == MD_CHG)
    // a response only appears after a registered request moved forward
    `BCP_ASSERT_NOW(a_rsp_from_req, $rose(out_vld_reg), $past(in_vld_reg))
    // fault hold keeps every counter cleared
    `BCP_ASSERT_NOW(a_fault_clears_cnt, ctrl_reg.st == ST_FAULT_HOLD,
        ctrl_reg.low_cnt == 16'd0 && ctrl_reg.high_cnt == 16'd0
        && ctrl_reg.idle_cnt == 16'd0 && ctrl_reg.rech_cnt == 16'd0)
    // charging never carries a close reason
    `BCP_ASSERT_NOW(a_chg_no_reason, ctrl_reg.st == ST_CHARGING, ctrl_reg.reason == RS_NONE)

endmodule

`default_nettype wire

// ===== tb/tb_battery_charge_permission_fsm_top.sv =====
// self-checking testbench for battery_charge_permission_fsm_top: directed and random ticks
// depends on bcp_pkg, bcp_if and the rtl of the block; predicts every response on its own
`timescale 1ns / 100ps

module tb_battery_charge_permission_fsm_top;
    import bcp_pkg::*;

    // block parameters, kept equal to the rtl defaults
    localparam int unsigned ABSENT_TICKS      = 10;
    localparam int unsigned SETTLE_TICKS      = 10;
    localparam int unsigned TARGET_SERIES_CNT = 16;

    localparam int NUM_LIMITS     = 8;
    localparam int DRAIN_CYCLES   = 6;     // margin for the pipe to empty
    localparam int END_CYCLES     = 8;
    localparam int HOLD_AFTER     = 700;   // responses checked before the long hold-off
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // thresholds after reset, in register order (packed msb first)
    localparam cfg_t RESET_LIMITS = {16'd10, 16'd5840, 16'd3650, 16'd5440,
                                     16'd3400, 16'd10, 16'd500, 16'd100};
    // same voltages, every tick count at one so the whole cycle fits in a few requests
    localparam cfg_t SHORT_LIMITS = {16'd10, 16'd5840, 16'd3650, 16'd5440,
                                     16'd3400, 16'd1, 16'd1, 16'd1};

    typedef enum int {ZONE_MID, ZONE_FULL, ZONE_RECHARGE} zone_e;
    typedef enum int {BAD_SERIES, BAD_CELL_LOW, BAD_CELL_HIGH, BAD_CELL_ORDER,
                      BAD_PACK} bad_data_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    bcp_req_if in_ch ();
    bcp_rsp_if out_ch ();

    battery_charge_permission_fsm_top #(
        .ABSENT_CONFIRM_TICKS (ABSENT_TICKS),
        .PROBE_SETTLE_TICKS   (SETTLE_TICKS),
        .TARGET_SERIES        (TARGET_SERIES_CNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // requests waiting to be offered, and the responses they must produce
    req_t pending_ticks [$];
    rsp_t expected_status [$];
    int   mismatches = 0;

    // ---------------------------------------------------------------------
    // charge permission predictor: own copy of thresholds and state
    // ---------------------------------------------------------------------
    cfg_t        limits;
    logic [2:0]  chg_state;
    logic [1:0]  presence;
    logic [2:0]  close_rsn;
    logic [1:0]  pack_mode_q;
    logic [15:0] low_ticks;     // consecutive detect-high samples
    logic [15:0] high_ticks;    // consecutive detect-low samples, also probe settle
    logic [15:0] dry_ticks;     // charging ticks without current
    logic [15:0] rech_ticks;    // ticks in the recharge zone with charger present
    logic        det_seen;

    function automatic logic [15:0] count_to(input logic [15:0] v, input logic [15:0] cap);
        return (v < cap) ? v + 16'd1 : v;
    endfunction

    task automatic clear_tick_counts();
        low_ticks  = '0;
        high_ticks = '0;
        dry_ticks  = '0;
        rech_ticks = '0;
    endtask

    task automatic reset_predictor();
        limits      = RESET_LIMITS;
        chg_state   = ST_WAIT;
        presence    = PR_UNKNOWN;
        close_rsn   = RS_NO_CHARGER;
        pack_mode_q = MD_STARTUP;
        det_seen    = 1'b0;
        clear_tick_counts();
    endtask

    // debounce of the charger detect pin
    task automatic sample_detect(input logic det);
        det_seen = det;
        if (det)
        begin
            if (presence == PR_ABSENT)
                presence = PR_UNKNOWN;
            low_ticks  = count_to(low_ticks, limits.present_confirm_ticks);
            high_ticks = '0;
            if (low_ticks >= limits.present_confirm_ticks)
                presence = PR_PRESENT;
        end
        else
        begin
            if (presence == PR_PRESENT)
                presence = PR_UNKNOWN;
            high_ticks = count_to(high_ticks, 16'(ABSENT_TICKS));
            low_ticks  = '0;
            if (high_ticks >= 16'(ABSENT_TICKS))
                presence = PR_ABSENT;
        end
    endtask

    task automatic trip_to_hold(input logic [2:0] why);
        chg_state = ST_FAULT_HOLD;
        presence  = PR_UNKNOWN;
        close_rsn = why;
        clear_tick_counts();
    endtask

    // advances the predictor by one tick and queues the response it implies
    task automatic compute_tick_status(input req_t t);
        logic force_off;
        logic want_chg;
        logic full_zone;
        logic rech_zone;
        rsp_t s;

        force_off = 1'b0;
        want_chg  = 1'b0;

        // pack mode follows the pins before the controller runs
        case (pack_mode_q)
            MD_STARTUP, MD_IDLE:
            begin
                force_off = 1'b1;
                if (t.load_detect)
                    pack_mode_q = MD_DSG;
                if (t.charger_detect)
                    pack_mode_q = MD_CHG;
            end
            MD_DSG:
            begin
                if (!t.load_detect)
                    pack_mode_q = MD_IDLE;
                if (t.charger_detect)
                    pack_mode_q = MD_CHG;
            end
            default:
            begin
                if (!t.load_detect)
                    force_off = 1'b1;
            end
        endcase

        full_zone = (t.pack_voltage >= limits.full_pack_voltage) &&
                    (t.cell_max_mv >= limits.full_cell_mv);
        rech_zone = (t.pack_voltage <= limits.recharge_pack_voltage) &&
                    (t.cell_max_mv <= limits.recharge_cell_mv);

        if (t.series_count != TARGET_SERIES_CNT || t.cell_min_mv < CELL_MIN_VALID_MV ||
            t.cell_max_mv > CELL_MAX_VALID_MV || t.cell_max_mv < t.cell_min_mv ||
            t.pack_voltage == 16'd0)
            trip_to_hold(RS_DATA_INVALID);
        else if (!t.prot_permit || t.fault_flags != '0)
            trip_to_hold(RS_PROTECTION);
        else
        begin
            case (chg_state)
                ST_WAIT:
                begin
                    close_rsn = RS_NO_CHARGER;
                    sample_detect(t.charger_detect);
                    if (presence == PR_PRESENT)
                    begin
                        chg_state = ST_CHARGING;
                        close_rsn = RS_NONE;
                        dry_ticks = '0;
                        want_chg  = 1'b1;
                    end
                end
                ST_CHARGING:
                begin
                    presence   = PR_UNKNOWN;
                    low_ticks  = '0;
                    high_ticks = '0;
                    close_rsn  = RS_NONE;
                    want_chg   = 1'b1;
                    if (t.charge_current >= limits.charge_evidence_current)
                        dry_ticks = '0;
                    else
                    begin
                        dry_ticks = count_to(dry_ticks, limits.no_current_ticks);
                        if (dry_ticks >= limits.no_current_ticks)
                        begin
                            // no current seen: switch off and look at the detect pin
                            chg_state = ST_PROBE_OFF;
                            close_rsn = RS_PROBE;
                            dry_ticks = '0;
                            want_chg  = 1'b0;
                        end
                    end
                end
                ST_PROBE_OFF:
                begin
                    close_rsn  = RS_PROBE;
                    high_ticks = count_to(high_ticks, 16'(SETTLE_TICKS));
                    if (high_ticks >= 16'(SETTLE_TICKS))
                    begin
                        chg_state  = ST_PROBE_SAMPLE;
                        low_ticks  = '0;
                        high_ticks = '0;
                    end
                end
                ST_PROBE_SAMPLE:
                begin
                    close_rsn = RS_PROBE;
                    sample_detect(t.charger_detect);
                    if (full_zone)
                    begin
                        chg_state  = ST_FULL_HOLD;
                        presence   = PR_UNKNOWN;
                        close_rsn  = RS_FULL;
                        low_ticks  = '0;
                        high_ticks = '0;
                        rech_ticks = '0;
                    end
                    else if (presence == PR_ABSENT)
                    begin
                        chg_state = ST_WAIT;
                        close_rsn = RS_NO_CHARGER;
                    end
                end
                ST_FULL_HOLD:
                begin
                    close_rsn = RS_FULL;
                    sample_detect(t.charger_detect);
                    if (rech_zone && presence == PR_PRESENT)
                    begin
                        rech_ticks = count_to(rech_ticks, limits.recharge_confirm_ticks);
                        if (rech_ticks >= limits.recharge_confirm_ticks)
                        begin
                            chg_state  = ST_CHARGING;
                            close_rsn  = RS_NONE;
                            rech_ticks = '0;
                            want_chg   = 1'b1;
                        end
                    end
                    else
                        rech_ticks = '0;
                end
                default:
                begin
                    // fault hold and the unused codes: first clean tick goes back to wait
                    chg_state = ST_WAIT;
                    presence  = PR_UNKNOWN;
                    close_rsn = RS_NO_CHARGER;
                    clear_tick_counts();
                end
            endcase
        end

        if (want_chg)
            pack_mode_q = MD_CHG;
        else if (pack_mode_q == MD_CHG && chg_state == ST_WAIT && presence == PR_ABSENT)
            pack_mode_q = t.load_detect ? MD_DSG : MD_IDLE;

        s.charge_mos_on       = t.prot_permit & want_chg;
        s.charge_demand       = want_chg;
        s.discharge_force_off = force_off;
        s.controller_state    = chg_state;
        s.charger_presence    = presence;
        s.stop_cause          = close_rsn;
        s.pack_mode           = pack_mode_q;
        s.detect_low_seen     = det_seen;
        expected_status.push_back(s);
    endtask

    // ---------------------------------------------------------------------
    // request driver: bursts of random length, mostly separated by random gaps
    // ---------------------------------------------------------------------
    logic offering;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            offering = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                compute_tick_status(in_ch.payload);
                void'(pending_ticks.pop_front());
                offering = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // one burst in four runs long and back to back
                    if ($urandom_range(3, 0) == 0)
                    begin
                        burst_left = $urandom_range(150, 50);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(12, 1);
                        gap_left   = $urandom_range(8, 1);
                    end
                end
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ticks.size() > 0)
                begin
                    in_ch.payload <= pending_ticks[0];
                    offering = 1'b1;
                end
            end
            // a held request stays up, a new one goes up: one assignment either way
            in_ch.valid <= offering;
        end
    end

    // ---------------------------------------------------------------------
    // response monitor and checker, with its own stall pattern
    // ---------------------------------------------------------------------
    int   checked = 0;
    int   pattern_cnt = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic ready_next;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: response with no request outstanding, expected none actual %h",
                             $time, out_ch.payload);
                    mismatches++;
                end
                else
                begin
                    rsp_t want;
                    want = expected_status.pop_front();
                    check_field("charge_mos_on", want.charge_mos_on,
                                out_ch.payload.charge_mos_on);
                    check_field("charge_demand", want.charge_demand,
                                out_ch.payload.charge_demand);
                    check_field("discharge_force_off", want.discharge_force_off,
                                out_ch.payload.discharge_force_off);
                    check_field("controller_state", want.controller_state,
                                out_ch.payload.controller_state);
                    check_field("charger_presence", want.charger_presence,
                                out_ch.payload.charger_presence);
                    check_field("stop_cause", want.stop_cause,
                                out_ch.payload.stop_cause);
                    check_field("pack_mode", want.pack_mode, out_ch.payload.pack_mode);
                    check_field("detect_low_seen", want.detect_low_seen,
                                out_ch.payload.detect_low_seen);
                end
                checked++;
            end

            // stall windows cycle through: always ready, coin flip, one in three,
            // mostly stalled; one long hold-off lets the block fill and stall its input
            pattern_cnt++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!hold_done && checked >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES;
                ready_next = 1'b0;
            end
            else
            begin
                case ((pattern_cnt / 128) % 4)
                    0: ready_next = 1'b1;
                    1: ready_next = 1'($urandom_range(1, 0));
                    2: ready_next = (pattern_cnt % 3 == 0);
                    default: ready_next = ($urandom_range(3, 0) == 0);
                endcase
            end
            out_ch.ready <= ready_next;
        end
    end

    // watchdog: too long without any handshake ends the run
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("battery_charge_permission_fsm_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // a clean tick: permission on, no faults, series count as expected
    function automatic req_t clean_tick(input logic det, input logic load,
                                        input logic [15:0] ichg, input logic [15:0] pack,
                                        input logic [15:0] cmin, input logic [15:0] cmax);
        req_t t;
        t.charger_detect = det;
        t.load_detect    = load;
        t.prot_permit    = 1'b1;
        t.fault_flags    = '0;
        t.cell_min_mv    = cmin;
        t.cell_max_mv    = cmax;
        t.pack_voltage   = pack;
        t.charge_current = ichg;
        t.series_count   = 6'(TARGET_SERIES_CNT);
        return t;
    endfunction

    // random value in a range, landing on either bound now and then
    function automatic logic [15:0] pick_between(input logic [15:0] lo, input logic [15:0] hi);
        int unsigned r;
        r = $urandom_range(7, 0);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [15:0] clamp_cell(input logic [15:0] mv);
        if (mv < CELL_MIN_VALID_MV)
            return CELL_MIN_VALID_MV;
        if (mv > CELL_MAX_VALID_MV)
            return CELL_MAX_VALID_MV;
        return mv;
    endfunction

    function automatic cfg_t random_limits();
        cfg_t c;
        c.charge_evidence_current = 16'($urandom_range(300, 0));
        c.full_pack_voltage       = 16'($urandom_range(6200, 5500));
        c.full_cell_mv            = 16'($urandom_range(3800, 3500));
        c.recharge_pack_voltage   = 16'($urandom_range(5600, 5000));
        c.recharge_cell_mv        = 16'($urandom_range(3500, 3200));
        c.present_confirm_ticks   = 16'($urandom_range(6, 1));
        c.no_current_ticks        = 16'($urandom_range(25, 1));
        c.recharge_confirm_ticks  = 16'($urandom_range(10, 1));
        return c;
    endfunction

    // writes all eight thresholds back to back; only called with nothing in flight
    task automatic load_thresholds(input cfg_t c);
        logic [15:0] vals [NUM_LIMITS];
        vals[CFG_CHARGE_EVIDENCE]  = c.charge_evidence_current;
        vals[CFG_FULL_PACK]        = c.full_pack_voltage;
        vals[CFG_FULL_CELL]        = c.full_cell_mv;
        vals[CFG_RECHARGE_PACK]    = c.recharge_pack_voltage;
        vals[CFG_RECHARGE_CELL]    = c.recharge_cell_mv;
        vals[CFG_PRESENT_CONFIRM]  = c.present_confirm_ticks;
        vals[CFG_NO_CURRENT]       = c.no_current_ticks;
        vals[CFG_RECHARGE_CONFIRM] = c.recharge_confirm_ticks;
        for (int i = 0; i < NUM_LIMITS; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        limits = c;
    endtask

    // waits until every queued request has been answered, then lets the pipe empty
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || expected_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // invalid data in every form, protection, field extremes and recovery
    task automatic queue_directed_faults();
        req_t base;
        req_t t;
        base = clean_tick(1'b0, 1'b0, 16'd0, 16'd5300, 16'd3300, 16'd3350);
        pending_ticks.push_back('0);
        pending_ticks.push_back('1);
        pending_ticks.push_back(base);
        t = base;
        t.series_count = 6'(TARGET_SERIES_CNT - 1);
        pending_ticks.push_back(t);
        t = base;
        t.cell_min_mv = CELL_MIN_VALID_MV - 16'd1;
        pending_ticks.push_back(t);
        t = base;
        t.cell_max_mv = CELL_MAX_VALID_MV + 16'd1;
        pending_ticks.push_back(t);
        // max cell below min cell
        t = base;
        t.cell_min_mv = base.cell_max_mv + 16'd1;
        pending_ticks.push_back(t);
        t = base;
        t.pack_voltage = '0;
        pending_ticks.push_back(t);
        t = base;
        t.prot_permit = 1'b0;
        pending_ticks.push_back(t);
        t = base;
        t.fault_flags = 13'h1000;
        pending_ticks.push_back(t);
        t = base;
        t.fault_flags = 13'h0001;
        pending_ticks.push_back(t);
        pending_ticks.push_back(base);
        // widest valid readings, both pins high while waiting
        pending_ticks.push_back(clean_tick(1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                                           CELL_MIN_VALID_MV, CELL_MAX_VALID_MV));
    endtask

    // one lap through the controller states but fault hold, configured tick counts at one
    task automatic queue_directed_cycle();
        pending_ticks.push_back(clean_tick(1'b1, 1'b0, 16'd0, 16'd5300, 16'd3300, 16'd3350));
        pending_ticks.push_back(clean_tick(1'b1, 1'b0, 16'd0, 16'd5300, 16'd3300, 16'd3350));
        repeat (SETTLE_TICKS)
            pending_ticks.push_back(clean_tick(1'b0, 1'b0, 16'd0, 16'd5300, 16'd3300,
                                               16'd3350));
        // probe sample with the pack exactly at the full thresholds
        pending_ticks.push_back(clean_tick(1'b1, 1'b1, 16'd0, 16'd5840, 16'd3600, 16'd3650));
        // full hold, exactly at the recharge thresholds with the charger back
        pending_ticks.push_back(clean_tick(1'b1, 1'b0, 16'd20, 16'd5440, 16'd3350,
                                           16'd3400));
    endtask

    // segments of steady pins, current and voltage zone, salted with broken ticks
    task automatic queue_random_ticks(input int count);
        int          seg_left;
        logic        det_lvl;
        logic        load_lvl;
        logic        current_on;
        zone_e       zone;
        int unsigned roll;
        logic [15:0] lim;
        req_t        t;

        seg_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left   = $urandom_range(40, 3);
                det_lvl    = ($urandom_range(9, 0) < 7);
                load_lvl   = 1'($urandom_range(1, 0));
                current_on = 1'($urandom_range(1, 0));
                zone       = zone_e'($urandom_range(2, 0));
            end
            seg_left--;

            t = clean_tick(det_lvl, load_lvl, 16'd0, 16'd1, 16'd1000, 16'd1000);
            if ($urandom_range(19, 0) == 0)
                t.charger_detect = !det_lvl;
            if ($urandom_range(9, 0) == 0)
                t.load_detect = !load_lvl;

            case (zone)
                ZONE_FULL:
                begin
                    lim = (limits.full_pack_voltage == 16'd0) ? 16'd1
                                                               : limits.full_pack_voltage;
                    t.pack_voltage = pick_between(lim, 16'hFFFF);
                    t.cell_max_mv  = pick_between(clamp_cell(limits.full_cell_mv),
                                                  CELL_MAX_VALID_MV);
                end
                ZONE_RECHARGE:
                begin
                    lim = (limits.recharge_pack_voltage == 16'd0) ? 16'd1
                                                                   : limits.recharge_pack_voltage;
                    t.pack_voltage = pick_between(16'd1, lim);
                    t.cell_max_mv  = pick_between(CELL_MIN_VALID_MV,
                                                  clamp_cell(limits.recharge_cell_mv));
                end
                default:
                begin
                    t.pack_voltage = pick_between(16'd1, 16'hFFFF);
                    t.cell_max_mv  = pick_between(CELL_MIN_VALID_MV, CELL_MAX_VALID_MV);
                end
            endcase
            t.cell_min_mv = pick_between(CELL_MIN_VALID_MV, t.cell_max_mv);

            if (current_on || limits.charge_evidence_current == 16'd0)
                t.charge_current = pick_between(limits.charge_evidence_current, 16'hFFFF);
            else
                t.charge_current = pick_between(16'd0,
                                                limits.charge_evidence_current - 16'd1);

            roll = $urandom_range(99, 0);
            if (roll < 3)
            begin
                // raw noise on every field
                t.charger_detect = 1'($urandom_range(1, 0));
                t.load_detect    = 1'($urandom_range(1, 0));
                t.prot_permit    = 1'($urandom_range(1, 0));
                t.fault_flags    = 13'($urandom);
                t.cell_min_mv    = 16'($urandom);
                t.cell_max_mv    = 16'($urandom);
                t.pack_voltage   = 16'($urandom);
                t.charge_current = 16'($urandom);
                t.series_count   = 6'($urandom);
            end
            else if (roll < 6)
            begin
                case (bad_data_e'($urandom_range(4, 0)))
                    BAD_SERIES:
                    begin
                        t.series_count = 6'($urandom_range(63, 0));
                        if (t.series_count == TARGET_SERIES_CNT)
                            t.series_count = t.series_count + 6'd1;
                    end
                    BAD_CELL_LOW:
                        t.cell_min_mv = 16'($urandom_range(CELL_MIN_VALID_MV - 1, 0));
                    BAD_CELL_HIGH:
                        t.cell_max_mv = 16'($urandom_range(16'hFFFF, CELL_MAX_VALID_MV + 1));
                    BAD_CELL_ORDER:
                    begin
                        t.cell_max_mv = 16'($urandom_range(CELL_MAX_VALID_MV - 1,
                                                           CELL_MIN_VALID_MV));
                        t.cell_min_mv = 16'($urandom_range(CELL_MAX_VALID_MV,
                                                           t.cell_max_mv + 1));
                    end
                    default: t.pack_voltage = '0;
                endcase
            end
            else if (roll < 8)
                t.prot_permit = 1'b0;
            else if (roll < 10)
                t.fault_flags = 13'($urandom_range(13'h1FFF, 1));

            pending_ticks.push_back(t);
        end
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_predictor();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, first with the thresholds from reset
        queue_directed_faults();
        wait_drained();
        load_thresholds(SHORT_LIMITS);
        queue_directed_cycle();
        wait_drained();

        // zero thresholds are met at once
        load_thresholds('0);
        queue_random_ticks(100);
        wait_drained();

        // top thresholds: counters never reach them
        load_thresholds('1);
        queue_random_ticks(100);
        wait_drained();

        // reset values once, then short random thresholds
        for (int phase = 0; phase < 4; phase++)
        begin
            load_thresholds((phase == 0) ? RESET_LIMITS : random_limits());
            queue_random_ticks(310);
            wait_drained();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("battery_charge_permission_fsm_top test passed");
        else
            $display("battery_charge_permission_fsm_top test failed");
        $finish;
    end

endmodule
